>>> rtl/core/shb_pkg.sv
// ----------------------------------------------------------------------------
// shb_pkg
// shared types and constants for the spatial hash bucket list build unit
// ----------------------------------------------------------------------------
package shb_pkg;

    localparam int HEAD_DEPTH = 4096;
    localparam int INDEX_BITS = 16;
    localparam int ADDR_BITS  = (HEAD_DEPTH > 1) ? $clog2(HEAD_DEPTH) : 1;
    localparam int BUCKET_W   = 13;
    localparam int COORD_W    = 32;
    localparam int CELL_W     = 31;
    localparam int CNT_W      = 6;

    localparam logic [31:0] HASH_PX = 32'd73856093;
    localparam logic [31:0] HASH_PY = 32'd19349663;
    localparam logic [31:0] HASH_PZ = 32'd83492791;
    localparam logic [CELL_W-1:0] CELL_RESET = 31'd65536;

    localparam logic CMD_CLEAR  = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_HASH,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic div_step;
        logic hash;
        logic rd;
        logic wr;
        logic zero_out;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
    } sts_t;

endpackage

>>> rtl/core/shb_if.sv
// ----------------------------------------------------------------------------
// shb_in_if / shb_out_if
// valid/ready channels for command beats and result beats
// ----------------------------------------------------------------------------
interface shb_in_if;
    import shb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [INDEX_BITS-1:0] particle_index;
    logic signed [31:0]    pos_x;
    logic signed [31:0]    pos_y;
    logic signed [31:0]    pos_z;
    modport source (output valid, cmd, particle_index, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, cmd, particle_index, pos_x, pos_y, pos_z, output ready);
endinterface

interface shb_out_if;
    import shb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [BUCKET_W-1:0]   bucket;
    logic [INDEX_BITS-1:0] next_link;
    logic signed [31:0]    cell_x;
    logic signed [31:0]    cell_y;
    logic signed [31:0]    cell_z;
    modport source (output valid, bucket, next_link, cell_x, cell_y, cell_z, input ready);
    modport sink (input valid, bucket, next_link, cell_x, cell_y, cell_z, output ready);
endinterface

>>> rtl/core/shb_ram.sv
// ----------------------------------------------------------------------------
// shb_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module shb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

>>> rtl/core/shb_ctrl.sv
// ----------------------------------------------------------------------------
// shb_ctrl
// sequencer for clear sweeps and insert beats
// ----------------------------------------------------------------------------
module shb_ctrl
    import shb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_cmd,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output ctl_t ctl
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                ctl.clear_step = 1'b1;
                ctl.wr         = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = (in_cmd == CMD_INSERT) ? ST_DIV : ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                ctl.clear_step = 1'b1;
                ctl.wr         = 1'b1;
                if (sts.clear_done)
                begin
                    ctl.zero_out = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                ctl.hash   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ctl.rd     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ctl.wr       = 1'b1;
                ctl.out_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/core/shb_datapath.sv
// ----------------------------------------------------------------------------
// shb_datapath
// restoring dividers, hash, bucket head ram and result register
// ----------------------------------------------------------------------------
module shb_datapath
    import shb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CELL_W-1:0]     cfg_data,
    input  logic [INDEX_BITS-1:0] in_index,
    input  logic [31:0]           in_pos [3],
    input  ctl_t                  ctl,
    output sts_t                  sts,
    output logic [BUCKET_W-1:0]   bucket,
    output logic [INDEX_BITS-1:0] next_link,
    output logic [31:0]           cell_out [3]
);
    localparam logic [31:0] PRIME [3] = '{HASH_PX, HASH_PY, HASH_PZ};

    logic [CELL_W-1:0]     cell_size_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [ADDR_BITS:0]    clr_reg;
    logic [INDEX_BITS-1:0] pidx_reg;
    logic                  neg_reg [3];
    logic                  nz_reg  [3];
    logic [31:0]           quo_reg [3];
    logic [31:0]           rem_reg [3];
    logic [31:0]           coord   [3];
    logic [31:0]           coord_reg [3];
    logic [31:0]           prod_reg  [3];
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [INDEX_BITS-1:0] ram_wdata;
    logic [INDEX_BITS-1:0] ram_rdata;
    logic [31:0]           hash;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CELL_RESET;
        end
        else if (cfg_we)
        begin
            cell_size_reg <= cfg_data;
        end
    end

    // saturating signed result from magnitude quotient
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cell_size_reg == '0)
            begin
                coord[i] = !nz_reg[i] ? 32'd0 : (neg_reg[i] ? 32'h80000000 : 32'h7FFFFFFF);
            end
            else if (neg_reg[i])
            begin
                coord[i] = 32'd0 - quo_reg[i];
            end
            else
            begin
                coord[i] = quo_reg[i][31] ? 32'h7FFFFFFF : quo_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            pidx_reg <= in_index;
            for (int i = 0; i < 3; i++)
            begin
                neg_reg[i] <= in_pos[i][31];
                nz_reg[i]  <= in_pos[i] != '0;
                quo_reg[i] <= in_pos[i][31] ? (32'd0 - in_pos[i]) : in_pos[i];
                rem_reg[i] <= '0;
            end
        end
        else if (ctl.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [32:0] trial;
                trial = {rem_reg[i], quo_reg[i][31]} - {2'b00, cell_size_reg};
                if (!trial[32])
                begin
                    rem_reg[i] <= trial[31:0];
                    quo_reg[i] <= {quo_reg[i][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i] <= {rem_reg[i][30:0], quo_reg[i][31]};
                    quo_reg[i] <= {quo_reg[i][30:0], 1'b0};
                end
            end
        end
        if (ctl.hash)
        begin
            for (int i = 0; i < 3; i++)
            begin
                coord_reg[i] <= coord[i];
                prod_reg[i]  <= coord[i] * PRIME[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            if (ctl.load)
            begin
                cnt_reg <= '0;
                clr_reg <= '0;
            end
            else
            begin
                if (ctl.div_step)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (ctl.clear_step)
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
            end
        end
    end

    assign sts.div_done   = cnt_reg == CNT_W'(31);
    assign sts.clear_done = clr_reg == (ADDR_BITS+1)'(HEAD_DEPTH - 1);

    assign hash = prod_reg[0] ^ prod_reg[1] ^ prod_reg[2];

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            addr_reg <= hash[ADDR_BITS-1:0];
        end
    end

    assign ram_addr  = ctl.clear_step ? clr_reg[ADDR_BITS-1:0]
                     : (ctl.rd ? hash[ADDR_BITS-1:0] : addr_reg);
    assign ram_wdata = ctl.clear_step ? '0 : pidx_reg;

    shb_ram #(.WIDTH(INDEX_BITS), .DEPTH(HEAD_DEPTH)) u_heads (
        .clk   (clk),
        .we    (ctl.wr),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.zero_out)
        begin
            bucket    <= '0;
            next_link <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cell_out[i] <= '0;
            end
        end
        else if (ctl.out_load)
        begin
            bucket    <= BUCKET_W'({1'b0, addr_reg} + (ADDR_BITS+1)'(1));
            next_link <= ram_rdata;
            for (int i = 0; i < 3; i++)
            begin
                cell_out[i] <= coord_reg[i];
            end
        end
    end
endmodule

>>> rtl/core/spatial_hash_bucket_list_build_unit.sv
// ----------------------------------------------------------------------------
// spatial_hash_bucket_list_build_unit
// builds per-bucket particle link lists from hashed cell coordinates
//
// channel   dir  beat
// in        in   cmd, particle_index, pos_x, pos_y, pos_z
// out       out  bucket, next_link, cell_x, cell_y, cell_z
// cfg       in   cell_size write, no index
//
// an insert is accepted, divided by the bit serial restoring dividers,
// hashed, read and written, and gives one result beat; a clear sweeps
// every entry of the head ram, then gives one result beat; after reset
// the same sweep empties the heads before the first beat is taken; a
// stalled result holds and blocks the next beat
// ----------------------------------------------------------------------------
module spatial_hash_bucket_list_build_unit
    import shb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CELL_W-1:0] cfg_data,
    shb_in_if.sink            in_ch,
    shb_out_if.source         out_ch
);
    ctl_t        ctl;
    sts_t        sts;
    logic [31:0] pos      [3];
    logic [31:0] cell_out [3];

    assign pos[0] = in_ch.pos_x;
    assign pos[1] = in_ch.pos_y;
    assign pos[2] = in_ch.pos_z;

    shb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    shb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_index  (in_ch.particle_index),
        .in_pos    (pos),
        .ctl       (ctl),
        .sts       (sts),
        .bucket    (out_ch.bucket),
        .next_link (out_ch.next_link),
        .cell_out  (cell_out)
    );

    assign out_ch.cell_x = cell_out[0];
    assign out_ch.cell_y = cell_out[1];
    assign out_ch.cell_z = cell_out[2];
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives insert and clear beats into the bucket list builder under random
// stalls on both channels, predicts cell coordinates, bucket and next link
// for every beat, and checks each result beat in order
// ----------------------------------------------------------------------------
import shb_pkg::*;

typedef struct {
    logic [BUCKET_W-1:0]   bucket;
    logic [INDEX_BITS-1:0] next_link;
    logic [31:0]           cell_x;
    logic [31:0]           cell_y;
    logic [31:0]           cell_z;
} link_beat_t;

class bucket_link_board;
    link_beat_t            pending_links[$];
    logic [INDEX_BITS-1:0] heads [HEAD_DEPTH];
    logic [CELL_W-1:0]     cell_size;
    int                    errors;

    function new();
        cell_size = CELL_RESET;
        errors    = 0;
        foreach (heads[i]) heads[i] = '0;
    endfunction

    function logic [31:0] cell_of(logic [31:0] raw, logic [CELL_W-1:0] c);
        logic        neg;
        logic [32:0] mag;
        logic [63:0] q;
        neg = raw[31];
        mag = neg ? ({1'b0, ~raw} + 33'd1) : {1'b0, raw};
        if (c == '0)
        begin
            if (mag == '0) return 32'd0;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        q = 64'(mag) / 64'(c);
        if (neg)
        begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'd0 - q[31:0];
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function void note_beat(logic cmd, logic [INDEX_BITS-1:0] idx,
                            logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        link_beat_t r;
        logic [31:0] h;
        int slot;
        if (cmd == CMD_CLEAR)
        begin
            foreach (heads[i]) heads[i] = '0;
            r.bucket = '0; r.next_link = '0;
            r.cell_x = '0; r.cell_y = '0; r.cell_z = '0;
        end
        else
        begin
            r.cell_x = cell_of(px, cell_size);
            r.cell_y = cell_of(py, cell_size);
            r.cell_z = cell_of(pz, cell_size);
            h = (r.cell_x * HASH_PX) ^ (r.cell_y * HASH_PY) ^ (r.cell_z * HASH_PZ);
            slot = int'(h % HEAD_DEPTH);
            r.bucket    = BUCKET_W'(slot + 1);
            r.next_link = heads[slot];
            heads[slot] = idx;
        end
        pending_links = {pending_links, r};
    endfunction

    function void check_beat(link_beat_t got);
        link_beat_t e;
        if (pending_links.size() == 0)
        begin
            $error("result beat with nothing expected");
            errors++;
            return;
        end
        e = pending_links.pop_front();
        if (got.bucket !== e.bucket)
        begin
            $error("bucket exp %0d got %0d", e.bucket, got.bucket);
            errors++;
        end
        if (got.next_link !== e.next_link)
        begin
            $error("next_link exp %0d got %0d", e.next_link, got.next_link);
            errors++;
        end
        if (got.cell_x !== e.cell_x)
        begin
            $error("cell_x exp %h got %h", e.cell_x, got.cell_x);
            errors++;
        end
        if (got.cell_y !== e.cell_y)
        begin
            $error("cell_y exp %h got %h", e.cell_y, got.cell_y);
            errors++;
        end
        if (got.cell_z !== e.cell_z)
        begin
            $error("cell_z exp %h got %h", e.cell_z, got.cell_z);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL        = 60;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CELL_W-1:0] cfg_data = '0;
    int                cycles = 0;
    bit                no_gaps = 1'b0;
    logic [31:0]       recent [8];

    bucket_link_board board = new();

    shb_in_if  in_ch();
    shb_out_if out_ch();

    spatial_hash_bucket_list_build_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        in_ch.valid          = 1'b0;
        in_ch.cmd            = CMD_CLEAR;
        in_ch.particle_index = '0;
        in_ch.pos_x          = '0;
        in_ch.pos_y          = '0;
        in_ch.pos_z          = '0;
        out_ch.ready         = 1'b0;
    end

    // result side
    initial
    begin
        link_beat_t got;
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
            got.bucket    = out_ch.bucket;
            got.next_link = out_ch.next_link;
            got.cell_x    = out_ch.cell_x;
            got.cell_y    = out_ch.cell_y;
            got.cell_z    = out_ch.cell_z;
            board.check_beat(got);
        end
    end

    task automatic send_beat(logic cmd, logic [INDEX_BITS-1:0] idx,
                             logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.cmd            <= cmd;
        in_ch.particle_index <= idx;
        in_ch.pos_x          <= px;
        in_ch.pos_y          <= py;
        in_ch.pos_z          <= pz;
        in_ch.valid          <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        board.note_beat(cmd, idx, px, py, pz);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (board.pending_links.size() != 0);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic write_cell_size(logic [CELL_W-1:0] value);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.cell_size = value;
    endtask

    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return $urandom();
        if (sel < 7) return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        if (sel < 9) return recent[$urandom_range(0, 7)];
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'd0;
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [31:0] px, py, pz;
        for (int n = 0; n < count; n++)
        begin
            if (n % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            if (n == count / 2) drain();
            if ($urandom_range(0, 199) == 0)
                send_beat(CMD_CLEAR, 16'($urandom()), $urandom(), $urandom(), $urandom());
            else
            begin
                px = pick_coord(); py = pick_coord(); pz = pick_coord();
                recent[$urandom_range(0, 7)] = px;
                send_beat(CMD_INSERT, 16'($urandom()), px, py, pz);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        logic [CELL_W-1:0] sizes [6];
        foreach (recent[i]) recent[i] = $urandom();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // heads start empty after reset
        send_beat(CMD_INSERT, 16'd1, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_INSERT, 16'd2, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_INSERT, 16'hFFFF, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_INSERT, 16'd0, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_INSERT, 16'd5, 32'd0, 32'd0, 32'd0);
        send_beat(CMD_INSERT, 16'd6, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 16'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_beat(CMD_INSERT, 16'd8, 32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFE_FFFF);
        send_beat(CMD_INSERT, 16'd9, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 16'd10, 32'd0, 32'd0, 32'd0);

        write_cell_size(31'd1);
        send_beat(CMD_INSERT, 16'd11, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        send_beat(CMD_INSERT, 16'd12, 32'hFFFF_FFFF, 32'd0, 32'h8000_0001);
        write_cell_size(31'h7FFF_FFFF);
        send_beat(CMD_INSERT, 16'd13, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
        send_beat(CMD_INSERT, 16'd14, 32'h8000_0001, 32'h7FFF_FFFE, 32'd0);
        write_cell_size(31'd0);
        send_beat(CMD_INSERT, 16'd15, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_beat(CMD_INSERT, 16'd16, 32'hFFFF_FFFF, 32'd1, 32'd0);
        send_beat(CMD_INSERT, 16'd17, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);

        sizes[0] = CELL_RESET;
        sizes[1] = 31'd0;
        sizes[2] = 31'd1;
        sizes[3] = 31'h7FFF_FFFF;
        sizes[4] = 31'd32768;
        sizes[5] = 31'($urandom());
        foreach (sizes[i])
        begin
            write_cell_size(sizes[i]);
            random_phase(255);
        end

        drain();
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
rtl/core/shb_pkg.sv
rtl/core/shb_if.sv
rtl/core/shb_ram.sv
rtl/core/shb_ctrl.sv
rtl/core/shb_datapath.sv
rtl/core/spatial_hash_bucket_list_build_unit.sv
bench/tb_top.sv
